// File: rtl/core/cbcs_pkg.sv
package cbcs_pkg;

  // Fixed field widths of the result and the radius.
  localparam int unsigned RADIUS_W  = 15;
  localparam int unsigned CONTACT_W = 16;
  localparam int unsigned SQ_W      = 2 * RADIUS_W;

  typedef enum logic [2:0] {
    SIDE_NONE   = 3'd0,
    SIDE_LEFT   = 3'd1,
    SIDE_RIGHT  = 3'd2,
    SIDE_TOP    = 3'd3,
    SIDE_BOTTOM = 3'd4
  } side_t;

endpackage

// File: rtl/core/circle_box_collision_side_unit.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | circle_xy, radius, a_*, box_xy, b_*
// out     | output    | out_valid / out_ready | hit, circle_side, circle_contact, box_contact
//
// Four register stages: face and corner differences, absolute values and the
// side choice, the three 15x15 squares, then the distance compare into the
// output register. A beat passes the stage 1, 2 and 3 registers before out_valid
// rises, and one pair can be taken every cycle while the output is not stalled.
// Reset clears only the stage valid bits.
// A stall at the output holds each full stage with no empty stage after it; empty stages still fill.
module circle_box_collision_side_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2*COORD_BITS-1:0]        circle_xy,
  input  logic [14:0]                    radius,
  input  logic signed [COORD_BITS-1:0]   a_top,
  input  logic signed [COORD_BITS-1:0]   a_right,
  input  logic signed [COORD_BITS-1:0]   a_bottom,
  input  logic signed [COORD_BITS-1:0]   a_left,
  input  logic [2*COORD_BITS-1:0]        box_xy,
  input  logic signed [COORD_BITS-1:0]   b_top,
  input  logic signed [COORD_BITS-1:0]   b_right,
  input  logic signed [COORD_BITS-1:0]   b_bottom,
  input  logic signed [COORD_BITS-1:0]   b_left,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic [2:0]                     circle_side,
  output logic signed [15:0]             circle_contact,
  output logic signed [15:0]             box_contact
);
  import cbcs_pkg::*;

  localparam int unsigned W  = COORD_BITS;
  // Differences need two extra bits; DW is at least 17, above the 16 bits of the signed radius.
  localparam int unsigned DW = (COORD_BITS + 2 > 17) ? COORD_BITS + 2 : 17;

  // ---------------- stage 1 logic ----------------
  logic signed [DW-1:0] cx, cy, bx, by, r_e;
  logic signed [DW-1:0] at, ar, ab, al, bt, br, bb, bl;
  logic                 in_x, in_y, f_left, f_right, f_bottom, f_top;
  logic                 right_of, below;
  logic signed [DW-1:0] kx, ky;
  side_t                face_side, h_side, v_side;
  logic [CONTACT_W-1:0] face_cc, face_bc, h_cc, h_bc, v_cc, v_bc;

  assign cx  = DW'($signed(circle_xy[W-1:0]));
  assign cy  = DW'($signed(circle_xy[2*W-1:W]));
  assign bx  = DW'($signed(box_xy[W-1:0]));
  assign by  = DW'($signed(box_xy[2*W-1:W]));
  assign r_e = DW'($signed({1'b0, radius}));
  assign at  = DW'(a_top);
  assign ar  = DW'(a_right);
  assign ab  = DW'(a_bottom);
  assign al  = DW'(a_left);
  assign bt  = DW'(b_top);
  assign br  = DW'(b_right);
  assign bb  = DW'(b_bottom);
  assign bl  = DW'(b_left);

  assign in_y     = (cy < bt) && (cy > bb);
  assign in_x     = (cx < br) && (cx > bl);
  assign f_left   = (cx < bx) && in_y && ((bl - cx) < r_e);
  assign f_right  = (cx > bx) && in_y && ((cx - br) < r_e);
  assign f_bottom = (cy > by) && in_x && ((cy - bt) < r_e);
  assign f_top    = (cy < by) && in_x && ((bb - cy) < r_e);
  assign right_of = cx > bx;
  assign below    = cy < by;
  assign kx       = right_of ? br : bl;
  assign ky       = below ? bb : bt;

  // Contacts keep the low 16 bits of the sign-extended edge.
  always_comb begin
    face_side = SIDE_NONE;
    face_cc   = '0;
    face_bc   = '0;
    if (f_left) begin
      face_side = SIDE_LEFT;
      face_cc   = br[CONTACT_W-1:0];
      face_bc   = al[CONTACT_W-1:0];
    end else if (f_right) begin
      face_side = SIDE_RIGHT;
      face_cc   = bl[CONTACT_W-1:0];
      face_bc   = ar[CONTACT_W-1:0];
    end else if (f_bottom) begin
      face_side = SIDE_BOTTOM;
      face_cc   = bt[CONTACT_W-1:0];
      face_bc   = ab[CONTACT_W-1:0];
    end else if (f_top) begin
      face_side = SIDE_TOP;
      face_cc   = bb[CONTACT_W-1:0];
      face_bc   = at[CONTACT_W-1:0];
    end
  end

  always_comb begin
    if (right_of) begin
      h_side = SIDE_LEFT;
      h_cc   = br[CONTACT_W-1:0];
      h_bc   = al[CONTACT_W-1:0];
    end else begin
      h_side = SIDE_RIGHT;
      h_cc   = bl[CONTACT_W-1:0];
      h_bc   = ar[CONTACT_W-1:0];
    end
    if (below) begin
      v_side = SIDE_TOP;
      v_cc   = bb[CONTACT_W-1:0];
      v_bc   = at[CONTACT_W-1:0];
    end else begin
      v_side = SIDE_BOTTOM;
      v_cc   = bt[CONTACT_W-1:0];
      v_bc   = ab[CONTACT_W-1:0];
    end
  end

  // ---------------- stage registers ----------------
  logic adv1, adv2, adv3, adv4;
  logic s1_valid, s2_valid, s3_valid;

  logic                 s1_face, s1_corner;
  side_t                s1_face_side, s1_h_side, s1_v_side;
  logic [CONTACT_W-1:0] s1_face_cc, s1_face_bc, s1_h_cc, s1_h_bc, s1_v_cc, s1_v_bc;
  logic signed [DW-1:0] s1_dx, s1_dy, s1_lr, s1_tb, s1_r;

  logic                 s2_face, s2_corner;
  side_t                s2_side;
  logic [CONTACT_W-1:0] s2_cc, s2_bc;
  logic [RADIUS_W-1:0]  s2_ax, s2_ay, s2_r;

  logic                 s3_face, s3_corner;
  side_t                s3_side;
  logic [CONTACT_W-1:0] s3_cc, s3_bc;
  logic [SQ_W-1:0]      s3_sx, s3_sy, s3_sr;

  assign adv4     = !out_valid || out_ready;
  assign adv3     = !s3_valid || adv4;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= in_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
      if (adv3) begin
        s3_valid <= s2_valid;
      end
      if (adv4) begin
        out_valid <= s3_valid;
      end
    end
  end

  // Stage 1: face tests, corner differences and overlap depths.
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_face      <= face_side != SIDE_NONE;
      s1_corner    <= (cx != bx) && (cy != by);
      s1_face_side <= face_side;
      s1_face_cc   <= face_cc;
      s1_face_bc   <= face_bc;
      s1_h_side    <= h_side;
      s1_h_cc      <= h_cc;
      s1_h_bc      <= h_bc;
      s1_v_side    <= v_side;
      s1_v_cc      <= v_cc;
      s1_v_bc      <= v_bc;
      s1_dx        <= kx - cx;
      s1_dy        <= ky - cy;
      s1_lr        <= right_of ? (br - al) : (ar - bl);
      s1_tb        <= below ? (at - bb) : (bt - ab);
      s1_r         <= r_e;
    end
  end

  // Stage 2: absolute distances, the bound check and the side choice.
  logic signed [DW-1:0] abs_dx, abs_dy;
  logic                 bound_ok;

  assign abs_dx   = s1_dx[DW-1] ? -s1_dx : s1_dx;
  assign abs_dy   = s1_dy[DW-1] ? -s1_dy : s1_dy;
  assign bound_ok = (abs_dx < s1_r) && (abs_dy < s1_r);

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_face   <= s1_face;
      s2_corner <= s1_corner && bound_ok;
      s2_ax     <= abs_dx[RADIUS_W-1:0];
      s2_ay     <= abs_dy[RADIUS_W-1:0];
      s2_r      <= s1_r[RADIUS_W-1:0];
      if (s1_face) begin
        s2_side <= s1_face_side;
        s2_cc   <= s1_face_cc;
        s2_bc   <= s1_face_bc;
      end else if (s1_lr < s1_tb) begin
        s2_side <= s1_h_side;
        s2_cc   <= s1_h_cc;
        s2_bc   <= s1_h_bc;
      end else begin
        s2_side <= s1_v_side;
        s2_cc   <= s1_v_cc;
        s2_bc   <= s1_v_bc;
      end
    end
  end

  // Stage 3: squares.
  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_face   <= s2_face;
      s3_corner <= s2_corner;
      s3_side   <= s2_side;
      s3_cc     <= s2_cc;
      s3_bc     <= s2_bc;
      s3_sx     <= SQ_W'(s2_ax) * SQ_W'(s2_ax);
      s3_sy     <= SQ_W'(s2_ay) * SQ_W'(s2_ay);
      s3_sr     <= SQ_W'(s2_r) * SQ_W'(s2_r);
    end
  end

  // Stage 4: distance compare and the output register.
  logic [SQ_W:0] dist_sq;
  logic          hit_next;

  assign dist_sq  = {1'b0, s3_sx} + {1'b0, s3_sy};
  assign hit_next = s3_face || (s3_corner && (dist_sq < {1'b0, s3_sr}));

  always_ff @(posedge clk) begin
    if (adv4) begin
      hit            <= hit_next;
      circle_side    <= hit_next ? s3_side : SIDE_NONE;
      circle_contact <= hit_next ? s3_cc : '0;
      box_contact    <= hit_next ? s3_bc : '0;
    end
  end

endmodule

// File: rtl/core/cbcs_checker.sv
module cbcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [2:0]  circle_side,
  input logic [15:0] circle_contact,
  input logic [15:0] box_contact
);
  import cbcs_pkg::*;

  // A stalled result beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(circle_side)
      && $stable(circle_contact) && $stable(box_contact))
    else $error("result beat changed while stalled");

  a_hit_side: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hit == (circle_side != SIDE_NONE))
    else $error("hit flag disagrees with side");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> circle_contact == '0 && box_contact == '0)
    else $error("contacts not cleared on a miss");

  a_side_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> circle_side == SIDE_NONE || circle_side == SIDE_LEFT
      || circle_side == SIDE_RIGHT || circle_side == SIDE_TOP
      || circle_side == SIDE_BOTTOM)
    else $error("side code out of range");

endmodule

bind circle_box_collision_side_unit cbcs_checker u_cbcs_checker (.*);

// File: bench/contact_checker.sv
module contact_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [31:0]         circle_xy,
  input  logic [14:0]         radius,
  input  logic signed [15:0]  a_top,
  input  logic signed [15:0]  a_right,
  input  logic signed [15:0]  a_bottom,
  input  logic signed [15:0]  a_left,
  input  logic [31:0]         box_xy,
  input  logic signed [15:0]  b_top,
  input  logic signed [15:0]  b_right,
  input  logic signed [15:0]  b_bottom,
  input  logic signed [15:0]  b_left,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                hit,
  input  logic [2:0]          circle_side,
  input  logic signed [15:0]  circle_contact,
  input  logic signed [15:0]  box_contact,
  output int                  fails,
  output int                  open_results
);
  import cbcs_pkg::*;

  typedef struct {
    logic                  hit;
    side_t                 side;
    logic [CONTACT_W-1:0]  circle_c;
    logic [CONTACT_W-1:0]  box_c;
  } contact_t;

  contact_t contacts_due[$];

  initial begin
    fails = 0;
    open_results = 0;
  end

  function automatic contact_t predict_contact(
    logic [31:0] cxy, logic [14:0] rad,
    logic signed [15:0] at, logic signed [15:0] ar,
    logic signed [15:0] ab, logic signed [15:0] al,
    logic [31:0] bxy,
    logic signed [15:0] bt, logic signed [15:0] br,
    logic signed [15:0] bb, logic signed [15:0] bl);
    longint cx, cy, bx, by, r, kx, ky, dx, dy, lr, tb;
    longint at_v, ar_v, ab_v, al_v, bt_v, br_v, bb_v, bl_v;
    logic in_x, in_y, right_of, below;
    side_t side;
    contact_t res;
    cx = $signed(cxy[15:0]);
    cy = $signed(cxy[31:16]);
    bx = $signed(bxy[15:0]);
    by = $signed(bxy[31:16]);
    r = rad;
    at_v = at; ar_v = ar; ab_v = ab; al_v = al;
    bt_v = bt; br_v = br; bb_v = bb; bl_v = bl;
    side = SIDE_NONE;
    in_y = (cy < bt_v) && (cy > bb_v);
    in_x = (cx < br_v) && (cx > bl_v);
    if (cx < bx && in_y && bl_v - cx < r) begin
      side = SIDE_LEFT;
    end else if (cx > bx && in_y && cx - br_v < r) begin
      side = SIDE_RIGHT;
    end else if (cy > by && in_x && cy - bt_v < r) begin
      side = SIDE_BOTTOM;
    end else if (cy < by && in_x && bb_v - cy < r) begin
      side = SIDE_TOP;
    end else if (cx != bx && cy != by) begin
      // Corner test: nearest box corner against the radius, then the
      // smaller overlap decides between the horizontal and vertical side.
      right_of = cx > bx;
      below = cy < by;
      kx = right_of ? br_v : bl_v;
      ky = below ? bb_v : bt_v;
      dx = kx - cx;
      dy = ky - cy;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dx < r && dy < r && dx * dx + dy * dy < r * r) begin
        lr = right_of ? br_v - al_v : ar_v - bl_v;
        tb = below ? at_v - bb_v : bt_v - ab_v;
        if (lr < tb) side = right_of ? SIDE_LEFT : SIDE_RIGHT;
        else side = below ? SIDE_TOP : SIDE_BOTTOM;
      end
    end
    res.hit = (side != SIDE_NONE);
    res.side = side;
    case (side)
      SIDE_LEFT: begin
        res.circle_c = br; res.box_c = al;
      end
      SIDE_RIGHT: begin
        res.circle_c = bl; res.box_c = ar;
      end
      SIDE_BOTTOM: begin
        res.circle_c = bt; res.box_c = ab;
      end
      SIDE_TOP: begin
        res.circle_c = bb; res.box_c = at;
      end
      default: begin
        res.circle_c = '0; res.box_c = '0;
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want_v);
    $display("contact_checker: %s: got %0d, expected %0d", what, got, want_v);
    fails++;
  endtask

  always @(posedge clk) begin
    contact_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (contacts_due.size() == 0) begin
          report_mismatch("result beat with nothing pending", circle_side, SIDE_NONE);
        end else begin
          want = contacts_due.pop_front();
          if (hit !== want.hit)
            report_mismatch("hit", hit, want.hit);
          if (circle_side !== want.side)
            report_mismatch("circle_side", circle_side, want.side);
          if (circle_contact !== want.circle_c)
            report_mismatch("circle_contact", circle_contact, $signed(want.circle_c));
          if (box_contact !== want.box_c)
            report_mismatch("box_contact", box_contact, $signed(want.box_c));
        end
      end
      if (in_valid && in_ready)
        contacts_due.insert(contacts_due.size(), predict_contact(circle_xy, radius,
          a_top, a_right, a_bottom, a_left, box_xy, b_top, b_right, b_bottom, b_left));
    end
    open_results <= contacts_due.size();
  end

endmodule

// File: bench/tb.sv
module tb;

  localparam int RANDOM_PAIRS = 380;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 90;
  localparam int CALM_TAIL    = 50;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct {
    logic [31:0] circle_xy;
    logic [14:0] radius;
    logic [15:0] a_top, a_right, a_bottom, a_left;
    logic [31:0] box_xy;
    logic [15:0] b_top, b_right, b_bottom, b_left;
  } pair_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        circle_xy = '0;
  logic [14:0]        radius = '0;
  logic signed [15:0] a_top = '0;
  logic signed [15:0] a_right = '0;
  logic signed [15:0] a_bottom = '0;
  logic signed [15:0] a_left = '0;
  logic [31:0]        box_xy = '0;
  logic signed [15:0] b_top = '0;
  logic signed [15:0] b_right = '0;
  logic signed [15:0] b_bottom = '0;
  logic signed [15:0] b_left = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               hit;
  logic [2:0]         circle_side;
  logic signed [15:0] circle_contact;
  logic signed [15:0] box_contact;
  int                 fails;
  int                 open_results;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  circle_box_collision_side_unit dut (.*);
  contact_checker checker_i (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // Circle with a box hugging it, and a box given by center and half sizes.
  function automatic pair_t shape_pair(int cx, int cy, int r, int bx, int by, int hw, int hh);
    pair_t p;
    p.circle_xy = {16'(cy), 16'(cx)};
    p.radius    = 15'(r);
    p.a_top     = 16'(cy + r);
    p.a_bottom  = 16'(cy - r);
    p.a_right   = 16'(cx + r);
    p.a_left    = 16'(cx - r);
    p.box_xy    = {16'(by), 16'(bx)};
    p.b_top     = 16'(by + hh);
    p.b_bottom  = 16'(by - hh);
    p.b_right   = 16'(bx + hw);
    p.b_left    = 16'(bx - hw);
    return p;
  endfunction

  function automatic pair_t noise_pair();
    pair_t p;
    p.circle_xy = $urandom;
    p.radius    = $urandom_range(0, 32767);
    p.a_top     = $urandom;
    p.a_right   = $urandom;
    p.a_bottom  = $urandom;
    p.a_left    = $urandom;
    p.box_xy    = $urandom;
    p.b_top     = $urandom;
    p.b_right   = $urandom;
    p.b_bottom  = $urandom;
    p.b_left    = $urandom;
    return p;
  endfunction

  function automatic pair_t fill_pair(logic [15:0] circle_v, logic [14:0] rad,
                                      logic [15:0] box_v);
    pair_t p;
    p.circle_xy = {circle_v, circle_v};
    p.radius    = rad;
    p.a_top     = circle_v;
    p.a_right   = circle_v;
    p.a_bottom  = circle_v;
    p.a_left    = circle_v;
    p.box_xy    = {box_v, box_v};
    p.b_top     = box_v;
    p.b_right   = box_v;
    p.b_bottom  = box_v;
    p.b_left    = box_v;
    return p;
  endfunction

  function automatic pair_t well_formed_pair();
    int bx, by, hw, hh, r, cx, cy, reach_x, reach_y;
    pair_t p;
    if ($urandom_range(0, 9) == 0) begin
      // Wide geometry: big radius, edges may wrap around the field.
      bx = int'($urandom_range(0, 40000)) - 20000;
      by = int'($urandom_range(0, 40000)) - 20000;
      hw = $urandom_range(1, 6000);
      hh = $urandom_range(1, 6000);
      r  = $urandom_range(0, 32767);
    end else begin
      bx = int'($urandom_range(0, 8000)) - 4000;
      by = int'($urandom_range(0, 8000)) - 4000;
      hw = $urandom_range(1, 800);
      hh = $urandom_range(1, 800);
      r  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 1200);
    end
    reach_x = hw + r + 40;
    reach_y = hh + r + 40;
    cx = bx + int'($urandom_range(0, 2 * reach_x)) - reach_x;
    cy = by + int'($urandom_range(0, 2 * reach_y)) - reach_y;
    case ($urandom_range(0, 9))
      0: cx = bx;
      1: cy = by;
      2: cy = by + hh;
      3: cx = bx - hw;
      default: ;
    endcase
    p = shape_pair(cx, cy, r, bx, by, hw, hh);
    if ($urandom_range(0, 5) == 0) begin
      p.a_top   = p.a_top + 16'($urandom_range(0, 64)) - 16'd32;
      p.a_right = p.a_right + 16'($urandom_range(0, 64)) - 16'd32;
      p.a_left  = p.a_left + 16'($urandom_range(0, 64)) - 16'd32;
      p.a_bottom = p.a_bottom + 16'($urandom_range(0, 64)) - 16'd32;
    end
    return p;
  endfunction

  task automatic send_pair(pair_t p);
    circle_xy <= p.circle_xy;
    radius    <= p.radius;
    a_top     <= p.a_top;
    a_right   <= p.a_right;
    a_bottom  <= p.a_bottom;
    a_left    <= p.a_left;
    box_xy    <= p.box_xy;
    b_top     <= p.b_top;
    b_right   <= p.b_right;
    b_bottom  <= p.b_bottom;
    b_left    <= p.b_left;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off, always ready in the tail.
  initial begin
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Box centered at the origin with edges at +/-160 for the first seventeen shaped cases.
    send_pair(shape_pair(-200, 0, 64, 0, 0, 160, 160));
    send_pair(shape_pair(200, 0, 64, 0, 0, 160, 160));
    send_pair(shape_pair(0, 200, 64, 0, 0, 160, 160));
    send_pair(shape_pair(0, -200, 64, 0, 0, 160, 160));
    send_pair(shape_pair(-300, 0, 64, 0, 0, 160, 160));
    send_pair(shape_pair(0, 0, 64, 0, 0, 160, 160));
    send_pair(shape_pair(190, 190, 64, 0, 0, 160, 160));
    send_pair(shape_pair(180, 200, 64, 0, 0, 160, 160));
    send_pair(shape_pair(200, 180, 64, 0, 0, 160, 160));
    send_pair(shape_pair(-200, -180, 64, 0, 0, 160, 160));
    send_pair(shape_pair(-180, -200, 64, 0, 0, 160, 160));
    send_pair(shape_pair(200, -180, 64, 0, 0, 160, 160));
    send_pair(shape_pair(-200, 180, 64, 0, 0, 160, 160));
    send_pair(shape_pair(210, 210, 64, 0, 0, 160, 160));
    send_pair(shape_pair(-150, 0, 0, 0, 0, 160, 160));
    send_pair(shape_pair(-160, 0, 0, 0, 0, 160, 160));
    send_pair(shape_pair(190, 190, 0, 0, 0, 160, 160));
    send_pair(shape_pair(-30000, 100, 32767, 30000, 0, 2000, 2000));
    send_pair(shape_pair(0, 0, 32767, 20000, 20000, 100, 100));
    send_pair(shape_pair(32700, 0, 200, 32000, 100, 500, 500));
    send_pair(fill_pair(16'h7FFF, 15'h7FFF, 16'h8000));
    send_pair(fill_pair(16'h8000, 15'h7FFF, 16'h7FFF));
    send_pair(fill_pair(16'h0000, 15'h0000, 16'h0000));
    send_pair(fill_pair(16'hFFFF, 15'h7FFF, 16'hFFFF));

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == RANDOM_PAIRS - CALM_TAIL) calm = 1'b1;
      // No sender gaps while the long hold-off is pending, so the pipe fills.
      if (!calm && (!hold_req || hold_done) && $urandom_range(0, 4) == 0)
        idle_gap($urandom_range(1, 18));
      if ($urandom_range(0, 3) == 0) send_pair(noise_pair());
      else send_pair(well_formed_pair());
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (open_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && open_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
